// ----- src/sdf_pkg.sv -----
// Shared types and constants of the substring delete filter.
package sdf_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned PLEN_W    = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_BYTES  = 2'd0,
    CFG_PATTERN_LENGTH = 2'd1,
    CFG_FIRST_ONLY     = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_RUN,
    S_PRE,
    S_FLUSH,
    S_END
  } state_e;

  typedef struct packed {
    logic ins_en;
    logic pop;
    logic clr;
  } cell_ctl_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              out_byte_valid;
    logic              out_last;
    logic              out_none_found;
  } res_t;

endpackage

// ----- src/sdf_if.sv -----
// Valid/ready channel interfaces for text bytes in and filtered results out.
interface sdf_in_if;
  logic                           valid;
  logic                           ready;
  logic [sdf_pkg::BYTE_W-1:0]     in_byte;
  logic                           in_last;

  modport source(output valid, output in_byte, output in_last, input ready);
  modport sink(input valid, input in_byte, input in_last, output ready);
endinterface

interface sdf_out_if;
  logic                           valid;
  logic                           ready;
  logic [sdf_pkg::BYTE_W-1:0]     out_byte;
  logic                           out_byte_valid;
  logic                           out_last;
  logic                           out_none_found;

  modport source(output valid, output out_byte, output out_byte_valid,
                 output out_last, output out_none_found, input ready);
  modport sink(input valid, input out_byte, input out_byte_valid,
               input out_last, input out_none_found, output ready);
endinterface

// ----- src/sdf_cell.sv -----
// One window cell: holds a byte, takes an insert or its right neighbor, compares to pattern.
module sdf_cell #(
  parameter int unsigned IDX_W = 4,
  parameter int unsigned IDX   = 0
) (
  input  logic                       clk_i,
  input  sdf_pkg::cell_ctl_t         ctl_i,
  input  logic [IDX_W-1:0]           held_i,
  input  logic [sdf_pkg::BYTE_W-1:0] in_byte_i,
  input  logic [sdf_pkg::BYTE_W-1:0] right_i,
  input  logic [sdf_pkg::BYTE_W-1:0] pat_i,
  output logic [sdf_pkg::BYTE_W-1:0] ins_o,
  output logic                       match_o
);

  logic [sdf_pkg::BYTE_W-1:0] byte_q;
  logic [sdf_pkg::BYTE_W-1:0] byte_d;

  assign ins_o   = (ctl_i.ins_en && (held_i == IDX_W'(IDX))) ? in_byte_i : byte_q;
  assign match_o = (ins_o == pat_i);

  always_comb begin
    if (ctl_i.clr) begin
      byte_d = '0;
    end else if (ctl_i.pop) begin
      byte_d = right_i;
    end else begin
      byte_d = ins_o;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

endmodule

// ----- src/sdf_obuf.sv -----
// Two-entry result buffer that drives the output channel.
module sdf_obuf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sdf_pkg::res_t    push_data_i,
  output logic             full_o,
  sdf_out_if.source        out_o
);

  sdf_pkg::res_t ent_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    count_q, count_d;
  logic          pop;
  sdf_pkg::res_t head;

  assign full_o    = (count_q == 2'd2);
  assign out_o.valid = (count_q != 2'd0);
  assign pop       = out_o.valid && out_o.ready;
  assign head      = ent_q[rd_ptr_q];

  assign out_o.out_byte       = head.out_byte;
  assign out_o.out_byte_valid = head.out_byte_valid;
  assign out_o.out_last       = head.out_last;
  assign out_o.out_none_found = head.out_none_found;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ----- src/substring_delete_filter_core.sv -----
// Top level of the substring delete filter: window cell row, sequencer and config registers.
//
// Text bytes enter on in_i, one item per byte, with in_last on the final byte.
// Filtered bytes leave on out_o; the final result of a text carries out_last
// and out_none_found, and is an end marker only (out_byte_valid low) when
// nothing is left to send. Configuration is written through cfg_we_i,
// cfg_idx_i and cfg_data_i, by the user only between texts; the block does not enforce this.
// A row of PATTERN_MAX cells holds the sliding window; all cells compare in
// parallel, so one item is accepted per cycle while the text streams and the
// result buffer has room. A byte leaves once pattern_length - 1 later bytes
// have been accepted, and is registered in the result buffer ahead of out_o.
// On the final item the window drains one byte per cycle while the result
// buffer has room, then the end result is formed. After a shortening of
// pattern_length the surplus bytes drain one per cycle, as the buffer allows,
// before the next item is stored.
// A two-entry result buffer sits at the output; when the receiver stalls it
// fills and in_i.ready drops, with no item lost.
// Reset empties the window, clears the found flag and the buffer, and sets
// the pattern to zero, pattern_length to 1 and every-occurrence mode.
module substring_delete_filter_core #(
  parameter int unsigned PATTERN_MAX = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  sdf_in_if.sink                        in_i,
  sdf_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [sdf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sdf_pkg::CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned CW = $clog2(PATTERN_MAX + 1);

  logic [sdf_pkg::CFG_W-1:0]  pat_q;
  logic [sdf_pkg::PLEN_W-1:0] plen_q;
  logic                       first_only_q;

  sdf_pkg::state_e            state_q, state_d;
  logic [CW-1:0]              held_q, held_d;
  logic                       removed_q, removed_d;
  logic [sdf_pkg::BYTE_W-1:0] pend_b_q, pend_b_d;
  logic                       pend_last_q, pend_last_d;
  logic [sdf_pkg::BYTE_W-1:0] stage_b_q, stage_b_d;
  logic                       stage_v_q, stage_v_d;

  logic [CW-1:0]              len;
  logic [PATTERN_MAX-1:0]     lane_en;
  logic [PATTERN_MAX-1:0]     cell_match;
  logic                       matched;
  logic                       surplus;
  logic                       full_win;
  logic                       cmp_en;
  logic                       full;
  logic                       accept;
  logic                       do_pop, do_step, cur_last;
  logic                       prod_v;
  logic [sdf_pkg::BYTE_W-1:0] step_b;
  logic [sdf_pkg::BYTE_W-1:0] ins_w [PATTERN_MAX+1];
  sdf_pkg::cell_ctl_t         ctl;
  logic                       push;
  sdf_pkg::res_t              push_data;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q        <= '0;
      plen_q       <= sdf_pkg::PLEN_W'(1);
      first_only_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (sdf_pkg::cfg_idx_e'(cfg_idx_i))
        sdf_pkg::CFG_PATTERN_BYTES:  pat_q        <= cfg_data_i;
        sdf_pkg::CFG_PATTERN_LENGTH: plen_q       <= cfg_data_i[sdf_pkg::PLEN_W-1:0];
        sdf_pkg::CFG_FIRST_ONLY:     first_only_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (plen_q == '0) begin
      len = CW'(1);
    end else if (plen_q > sdf_pkg::PLEN_W'(PATTERN_MAX)) begin
      len = CW'(PATTERN_MAX);
    end else begin
      len = plen_q[CW-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      lane_en[i] = (CW'(i) < len);
    end
  end

  assign matched  = &(cell_match | ~lane_en);
  assign surplus  = (held_q >= len);
  assign full_win = (held_q == CW'(len - CW'(1)));
  assign cmp_en   = !(first_only_q && removed_q);
  assign accept   = in_i.valid && in_i.ready;
  assign ins_w[PATTERN_MAX] = '0;

  // Window cell row
  for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
    sdf_cell #(
      .IDX_W(CW),
      .IDX  (g)
    ) u_cell (
      .clk_i    (clk_i),
      .ctl_i    (ctl),
      .held_i   (held_q),
      .in_byte_i(step_b),
      .right_i  (ins_w[g+1]),
      .pat_i    (pat_q[sdf_pkg::BYTE_W*g +: sdf_pkg::BYTE_W]),
      .ins_o    (ins_w[g]),
      .match_o  (cell_match[g])
    );
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    held_d      = held_q;
    removed_d   = removed_q;
    pend_b_d    = pend_b_q;
    pend_last_d = pend_last_q;
    stage_b_d   = stage_b_q;
    stage_v_d   = stage_v_q;
    in_i.ready  = 1'b0;
    do_pop      = 1'b0;
    do_step     = 1'b0;
    cur_last    = 1'b0;
    step_b      = in_i.in_byte;
    ctl         = '0;
    prod_v      = 1'b0;
    push        = 1'b0;
    push_data   = '0;

    case (state_q)
      sdf_pkg::S_RUN: begin
        in_i.ready = !full;
        if (accept) begin
          pend_b_d    = in_i.in_byte;
          pend_last_d = in_i.in_last;
          cur_last    = in_i.in_last;
          if (surplus) begin
            do_pop  = 1'b1;
            state_d = sdf_pkg::S_PRE;
          end else begin
            do_step = 1'b1;
          end
        end
      end
      sdf_pkg::S_PRE: begin
        step_b = pend_b_q;
        if (!full) begin
          cur_last = pend_last_q;
          if (surplus) begin
            do_pop = 1'b1;
          end else begin
            do_step = 1'b1;
          end
        end
      end
      sdf_pkg::S_FLUSH: begin
        if (!full) begin
          cur_last = 1'b1;
          do_pop   = 1'b1;
          if (held_q == CW'(1)) begin
            state_d = sdf_pkg::S_END;
          end
        end
      end
      sdf_pkg::S_END: begin
        if (!full) begin
          push                     = 1'b1;
          push_data.out_byte       = stage_v_q ? stage_b_q : '0;
          push_data.out_byte_valid = stage_v_q;
          push_data.out_last       = 1'b1;
          push_data.out_none_found = !removed_q;
          stage_v_d                = 1'b0;
          removed_d                = 1'b0;
          held_d                   = '0;
          state_d                  = sdf_pkg::S_RUN;
        end
      end
      default: begin
        state_d = sdf_pkg::S_RUN;
      end
    endcase

    if (do_pop) begin
      ctl.pop = 1'b1;
      prod_v  = 1'b1;
      held_d  = held_q - CW'(1);
    end

    if (do_step) begin
      ctl.ins_en = 1'b1;
      if (full_win && cmp_en && matched) begin
        ctl.clr   = 1'b1;
        held_d    = '0;
        removed_d = 1'b1;
      end else if (full_win) begin
        ctl.pop = 1'b1;
        prod_v  = 1'b1;
      end else begin
        held_d = held_q + CW'(1);
      end
      if (!cur_last) begin
        state_d = sdf_pkg::S_RUN;
      end else if (held_d == '0) begin
        state_d = sdf_pkg::S_END;
      end else begin
        state_d = sdf_pkg::S_FLUSH;
      end
    end

    // Hold the newest byte of a final item back until it is known to be the last
    if (prod_v) begin
      if (cur_last) begin
        push                     = stage_v_q;
        push_data.out_byte       = stage_b_q;
        push_data.out_byte_valid = 1'b1;
        stage_b_d                = ins_w[0];
        stage_v_d                = 1'b1;
      end else begin
        push                     = 1'b1;
        push_data.out_byte       = ins_w[0];
        push_data.out_byte_valid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sdf_pkg::S_RUN;
      held_q      <= '0;
      removed_q   <= 1'b0;
      pend_last_q <= 1'b0;
      stage_v_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      removed_q   <= removed_d;
      pend_last_q <= pend_last_d;
      stage_v_q   <= stage_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_b_q  <= pend_b_d;
    stage_b_q <= stage_b_d;
  end

  sdf_obuf u_obuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (full),
    .out_o      (out_o)
  );

  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CW'(PATTERN_MAX))
    else $error("window count beyond cell row");

  a_flush_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sdf_pkg::S_FLUSH |-> held_q != '0)
    else $error("flush with empty window");

  a_end_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sdf_pkg::S_END |-> held_q == '0)
    else $error("end of text with bytes still held");

  a_stage_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sdf_pkg::S_RUN |-> !stage_v_q)
    else $error("held-back byte left over between texts");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sdf_pkg::S_END && !full) |=> (!removed_q && state_q == sdf_pkg::S_RUN))
    else $error("end of text did not clear state");

endmodule
